>>> rtl/core/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// shared types, codes and the crc byte step for the file checksum engine
// ----------------------------------------------------------------------------
package fce_pkg;

    localparam int unsigned SUM_W    = 32;
    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LANE_W   = 2;

    typedef enum logic [1:0] {
        KIND_MODULAR = 2'd0,
        KIND_CRC32C  = 2'd1,
        KIND_CRC32   = 2'd2,
        KIND_NULL    = 2'd3
    } kind_t;

    typedef logic [1:0] op_t;

    localparam op_t OP_DATA    = 2'd0;
    localparam op_t OP_FINISH  = 2'd1;
    localparam op_t OP_RESTART = 2'd2;

    localparam logic [SUM_W-1:0] ALL_ONES    = '1;
    localparam logic [SUM_W-1:0] POLY_CRC32C = 32'h82F6_3B78;
    localparam logic [SUM_W-1:0] POLY_CRC32  = 32'hEDB8_8320;

    // reflected crc, one byte folded in lsb first
    function automatic logic [SUM_W-1:0] crc_fold_byte(
        input logic [SUM_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input logic [SUM_W-1:0]  poly
    );
        logic [SUM_W-1:0] r;
        r = crc ^ {{(SUM_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (r[0])
            begin
                r = (r >> 1) ^ poly;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/file_checksum_engine.sv
// ----------------------------------------------------------------------------
// file_checksum_engine
// running 32-bit file checksum: modular sum, crc-32c, ieee crc-32 or null
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser carries the operation (data byte, finish,
// restart), tdata the byte offset and the data byte. Only a finish makes
// an output transfer on m_axis: tuser is the disorder flag, tdata the
// checksum. The user must write checksum_kind through cfg_wr_en / cfg_wr_data
// only while the block is idle; the block itself does not enforce this, and
// a restart should follow a kind change. An accepted item is held in the
// input register, then its state update (crc byte step, lane add, offset
// compare) is done in one pass and a finish lands in the output register.
// One item per cycle is sustained unless a finish waits behind a stalled result.
// The output register is a single stage; while the receiver stalls a
// waiting result, data bytes and restarts keep flowing, and a second
// finish holds in the input register, which then deasserts s_axis_tready.
// Reset clears the kind to modular, the checksum state and both stages.
// ----------------------------------------------------------------------------
module file_checksum_engine
    import fce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,      // checksum_kind

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,     // byte_offset[31:0], data_byte[39:32]
    input  logic [1:0]  s_axis_tuser,     // operation[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,     // checksum_value[31:0]
    output logic [0:0]  m_axis_tuser      // status[0]
);

    kind_t               kind_reg;
    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [OFFSET_W-1:0] in_offset_reg;
    logic [BYTE_W-1:0]   in_byte_reg;

    logic [SUM_W-1:0]    running_reg,  running_next;
    logic [OFFSET_W-1:0] expected_reg, expected_next;
    logic                begun_reg,    begun_next;
    logic                disorder_reg, disorder_next;

    logic                out_valid_reg;
    logic [SUM_W-1:0]    out_value_reg, out_value_next;
    logic                out_status_reg, out_status_next;

    logic                is_finish;
    logic                out_free;
    logic                advance;
    logic                in_take;
    logic                in_seq;
    logic [SUM_W-1:0]    lane_add;
    logic [SUM_W-1:0]    crc_c_in;

    assign is_finish     = in_valid_reg && (in_op_reg == OP_FINISH);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!is_finish || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_seq        = (in_offset_reg == expected_reg);
    assign crc_c_in      = begun_reg ? running_reg : ALL_ONES;

    // big-endian lane placement of the byte
    always_comb
    begin
        case (in_offset_reg[LANE_W-1:0])
            2'd0:    lane_add = {in_byte_reg, 24'd0};
            2'd1:    lane_add = {8'd0, in_byte_reg, 16'd0};
            2'd2:    lane_add = {16'd0, in_byte_reg, 8'd0};
            default: lane_add = {24'd0, in_byte_reg};
        endcase
    end

    // state update
    always_comb
    begin
        running_next  = running_reg;
        expected_next = expected_reg;
        begun_next    = begun_reg;
        disorder_next = disorder_reg;
        if (advance)
        begin
            case (in_op_reg)
                OP_RESTART:
                begin
                    running_next  = '0;
                    expected_next = '0;
                    begun_next    = 1'b0;
                    disorder_next = 1'b0;
                end
                OP_DATA:
                begin
                    case (kind_reg)
                        KIND_MODULAR:
                        begin
                            running_next = running_reg + lane_add;
                        end
                        KIND_CRC32C:
                        begin
                            if (!in_seq)
                            begin
                                disorder_next = 1'b1;
                            end
                            else if (!disorder_reg)
                            begin
                                running_next  = crc_fold_byte(crc_c_in, in_byte_reg,
                                                              POLY_CRC32C);
                                begun_next    = 1'b1;
                                expected_next = expected_reg + 1'b1;
                            end
                        end
                        KIND_CRC32:
                        begin
                            if (!in_seq)
                            begin
                                disorder_next = 1'b1;
                            end
                            else if (!disorder_reg)
                            begin
                                running_next  = ~crc_fold_byte(~running_reg, in_byte_reg,
                                                               POLY_CRC32);
                                expected_next = expected_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            running_next = running_reg;
                        end
                    endcase
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end
    end

    // finish result
    always_comb
    begin
        out_status_next = 1'b0;
        case (kind_reg)
            KIND_MODULAR:
            begin
                out_value_next = running_reg;
            end
            KIND_CRC32C:
            begin
                out_status_next = disorder_reg;
                out_value_next  = (disorder_reg || !begun_reg) ? '0 : ~running_reg;
            end
            KIND_CRC32:
            begin
                out_status_next = disorder_reg;
                out_value_next  = disorder_reg ? '0 : running_reg;
            end
            default:
            begin
                out_value_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_MODULAR;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= '0;
            expected_reg  <= '0;
            begun_reg     <= 1'b0;
            disorder_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                kind_reg <= kind_t'(cfg_wr_data);
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance && is_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            running_reg  <= running_next;
            expected_reg <= expected_next;
            begun_reg    <= begun_next;
            disorder_reg <= disorder_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg     <= s_axis_tuser;
            in_offset_reg <= s_axis_tdata[OFFSET_W-1:0];
            in_byte_reg   <= s_axis_tdata[OFFSET_W+BYTE_W-1:OFFSET_W];
        end
        if (advance && is_finish)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_status_reg;

endmodule
